### design/wrst_pkg.sv
// ----------------------------------------------------------------------------
// wrst_pkg: shared types and codes of the weighted random select tree
// Request, response and internal command layouts, action and status codes.
// ----------------------------------------------------------------------------
package wrst_pkg;

   // raw action codes on the request channel
   localparam logic [1:0] CODE_SET   = 2'd0;
   localparam logic [1:0] CODE_DRAW  = 2'd1;
   localparam logic [1:0] CODE_QUERY = 2'd2;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int TOTAL_W = 40;

   typedef enum logic [1:0] {
      ACT_SET   = 2'd0,
      ACT_DRAW  = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } act_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] ext_id;
      logic [31:0] weight;
      logic        weight_infinite;
      logic [31:0] random_fraction;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [31:0]        out_id;
      logic [31:0]        out_weight;
      logic               out_infinite;
      logic [TOTAL_W-1:0] total_weight;
      logic               total_infinite;
   } rsp_type;

   typedef struct packed {
      act_type     act;
      logic [31:0] ext_id;
      logic [31:0] weight;
      logic        weight_infinite;
      logic [31:0] random_fraction;
   } cmd_type;

endpackage

### design/wrst_req_if.sv
// ----------------------------------------------------------------------------
// wrst_req_if: request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface wrst_req_if;
   logic              valid;
   logic              ready;
   wrst_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/wrst_rsp_if.sv
// ----------------------------------------------------------------------------
// wrst_rsp_if: response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface wrst_rsp_if;
   logic              valid;
   logic              ready;
   wrst_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/wrst_front.sv
// ----------------------------------------------------------------------------
// wrst_front: request intake
// Decodes each request into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module wrst_front (
   input  logic              clock,
   input  logic              reset,
   wrst_req_if.sink          req,
   output logic              cmd_valid,
   output wrst_pkg::cmd_type cmd,
   input  logic              pop
);

   wrst_pkg::cmd_type q_ff [2];
   logic              wp_ff, wp_in;
   logic              rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   wrst_pkg::cmd_type dec;
   logic              push;

   // classify the action
   always_comb begin
      dec.ext_id          = req.payload.ext_id;
      dec.weight          = req.payload.weight;
      dec.weight_infinite = req.payload.weight_infinite;
      dec.random_fraction = req.payload.random_fraction;
      unique case (req.payload.action)
         wrst_pkg::CODE_SET:   dec.act = wrst_pkg::ACT_SET;
         wrst_pkg::CODE_DRAW:  dec.act = wrst_pkg::ACT_DRAW;
         wrst_pkg::CODE_QUERY: dec.act = wrst_pkg::ACT_QUERY;
         default:              dec.act = wrst_pkg::ACT_NONE;
      endcase
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   // advance pointers and count
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // store the transfer
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= dec;
      end
   end

endmodule

### design/wrst_back.sv
// ----------------------------------------------------------------------------
// wrst_back: command engine
// Id lookup, slot claim, sum path update and weighted tree descent over
// slot memories, with the response register.
// ----------------------------------------------------------------------------
module wrst_back #(
   parameter int SLOTS       = 256,
   parameter int WEIGHT_BITS = 32,
   parameter int RANDOM_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  wrst_pkg::cmd_type cmd,
   output logic              pop,
   wrst_rsp_if.source        rsp
);

   localparam int IDX_W  = $clog2(SLOTS + 1);
   localparam int NODE_W = IDX_W + 1;
   localparam int WB_EFF = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
   localparam int FR_EFF = (RANDOM_BITS < 32) ? RANDOM_BITS : 32;
   localparam int SUM_W  = WB_EFF + IDX_W;
   localparam int LO_W   = (SUM_W + 1) / 2;
   localparam int MUL_W  = LO_W + FR_EFF;
   localparam int PROD_W = SUM_W + FR_EFF;

   typedef enum logic [18:0] {
      S_IDLE     = 19'h00001,
      S_DISP     = 19'h00002,
      S_LOOK_RD  = 19'h00004,
      S_LOOK_CMP = 19'h00008,
      S_CLAIM    = 19'h00010,
      S_WGOT     = 19'h00020,
      S_APPLY    = 19'h00040,
      S_PATH_RD  = 19'h00080,
      S_PATH_WR  = 19'h00100,
      S_SCAN_RD  = 19'h00200,
      S_SCAN_CMP = 19'h00400,
      S_MUL1     = 19'h00800,
      S_MUL2     = 19'h01000,
      S_RSET     = 19'h02000,
      S_DRD      = 19'h04000,
      S_DW       = 19'h08000,
      S_DL       = 19'h10000,
      S_IDRD     = 19'h20000,
      S_IDGOT    = 19'h40000
   } state_type;

   // slot memories, entry 0 unused
   logic [WB_EFF:0]  mem_w  [0:SLOTS];
   logic [SUM_W-1:0] mem_s  [0:SLOTS];
   logic [31:0]      mem_id [0:SLOTS];

   logic             w_re, w_we, s_re, s_we, id_re, id_we;
   logic [IDX_W-1:0] w_ra, w_wa, s_ra, s_wa, id_ra, id_wa;
   logic [WB_EFF:0]  w_wd, w_rd_ff;
   logic [SUM_W-1:0] s_wd, s_rd_ff;
   logic [31:0]      id_wd, id_rd_ff;

   state_type         state_ff, state_in;
   wrst_pkg::cmd_type cmd_ff, cmd_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [NODE_W-1:0] scan_ff, scan_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic [IDX_W-1:0]  used_ff, used_in;
   logic [IDX_W-1:0]  infcnt_ff, infcnt_in;
   logic [SUM_W-1:0]  total_ff, total_in;
   logic [SUM_W-1:0]  r_ff, r_in;
   logic [SUM_W-1:0]  delta_ff, delta_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [WB_EFF:0]   old_ff, old_in;
   logic              wok_ff, wok_in, lok_ff, lok_in;
   logic              rv_ff, rv_in;
   wrst_pkg::rsp_type res_ff, res_in;

   logic              fin;
   logic [1:0]        fin_status;
   logic [31:0]       fin_id;
   logic [WB_EFF:0]   fin_w;
   logic [LO_W-1:0]   mop;
   logic [MUL_W-1:0]  mul_res;
   logic [WB_EFF-1:0] wm;
   logic [WB_EFF:0]   newv;
   logic [NODE_W-1:0] child;
   logic [SUM_W-1:0]  wv, left, sum_new;

   assign wm      = cmd_ff.weight[WB_EFF-1:0];
   assign newv    = cmd_ff.weight_infinite ? {1'b1, {WB_EFF{1'b0}}} : {1'b0, wm};
   assign mop     = (state_ff == S_MUL1) ? total_ff[LO_W-1:0]
                                         : LO_W'(total_ff[SUM_W-1:LO_W]);
   assign mul_res = MUL_W'(mop) * MUL_W'(cmd_ff.random_fraction[FR_EFF-1:0]);
   assign child   = NODE_W'({node_ff, 1'b0});
   assign wv      = wok_ff ? SUM_W'(w_rd_ff[WB_EFF-1:0]) : '0;
   assign left    = lok_ff ? s_rd_ff : '0;
   assign sum_new = s_rd_ff + delta_ff;

   assign pop         = (state_ff == S_IDLE) && cmd_valid && !rv_ff;
   assign rsp.valid   = rv_ff;
   assign rsp.payload = res_ff;

   // sequence one command
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      slot_in   = slot_ff;
      scan_in   = scan_ff;
      node_in   = node_ff;
      used_in   = used_ff;
      infcnt_in = infcnt_ff;
      total_in  = total_ff;
      r_in      = r_ff;
      delta_in  = delta_ff;
      prod_in   = prod_ff;
      old_in    = old_ff;
      wok_in    = wok_ff;
      lok_in    = lok_ff;
      rv_in     = rv_ff && !rsp.ready;
      res_in    = res_ff;
      w_re = 1'b0; w_ra = '0; w_we = 1'b0; w_wa = '0; w_wd = '0;
      s_re = 1'b0; s_ra = '0; s_we = 1'b0; s_wa = '0; s_wd = '0;
      id_re = 1'b0; id_ra = '0; id_we = 1'b0; id_wa = '0; id_wd = '0;
      fin        = 1'b0;
      fin_status = wrst_pkg::STATUS_OK;
      fin_id     = cmd_ff.ext_id;
      fin_w      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               cmd_in   = cmd;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            scan_in = NODE_W'(1);
            unique case (cmd_ff.act)
               wrst_pkg::ACT_SET, wrst_pkg::ACT_QUERY: state_in = S_LOOK_RD;
               wrst_pkg::ACT_DRAW: begin
                  if (infcnt_ff != '0) begin
                     state_in = S_SCAN_RD;
                  end else if (total_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = wrst_pkg::STATUS_EMPTY;
                     fin_id     = '0;
                  end else begin
                     state_in = S_MUL1;
                  end
               end
               default: fin = 1'b1;
            endcase
         end
         // walk the claimed slots for the id
         S_LOOK_RD: begin
            if (scan_ff > NODE_W'(used_ff)) begin
               state_in = S_CLAIM;
            end else begin
               id_re    = 1'b1;
               id_ra    = scan_ff[IDX_W-1:0];
               state_in = S_LOOK_CMP;
            end
         end
         S_LOOK_CMP: begin
            if (id_rd_ff == cmd_ff.ext_id) begin
               slot_in  = scan_ff[IDX_W-1:0];
               w_re     = 1'b1;
               w_ra     = scan_ff[IDX_W-1:0];
               state_in = S_WGOT;
            end else begin
               scan_in  = scan_ff + NODE_W'(1);
               state_in = S_LOOK_RD;
            end
         end
         S_CLAIM: begin
            if (used_ff == IDX_W'(SLOTS)) begin
               fin        = 1'b1;
               fin_status = wrst_pkg::STATUS_FULL;
            end else begin
               used_in = used_ff + IDX_W'(1);
               slot_in = used_ff + IDX_W'(1);
               id_we   = 1'b1;
               id_wa   = used_ff + IDX_W'(1);
               id_wd   = cmd_ff.ext_id;
               w_we    = 1'b1;
               w_wa    = used_ff + IDX_W'(1);
               s_we    = 1'b1;
               s_wa    = used_ff + IDX_W'(1);
               old_in  = '0;
               if (cmd_ff.act == wrst_pkg::ACT_QUERY) begin
                  fin = 1'b1;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_WGOT: begin
            old_in = w_rd_ff;
            if (cmd_ff.act == wrst_pkg::ACT_QUERY) begin
               fin   = 1'b1;
               fin_w = w_rd_ff;
            end else begin
               state_in = S_APPLY;
            end
         end
         // write the slot and start the path update
         S_APPLY: begin
            w_we     = 1'b1;
            w_wa     = slot_ff;
            w_wd     = newv;
            delta_in = SUM_W'(newv[WB_EFF-1:0]) - SUM_W'(old_ff[WB_EFF-1:0]);
            if (newv[WB_EFF] && !old_ff[WB_EFF]) begin
               infcnt_in = infcnt_ff + IDX_W'(1);
            end else if (!newv[WB_EFF] && old_ff[WB_EFF]) begin
               infcnt_in = infcnt_ff - IDX_W'(1);
            end
            old_in   = newv;
            node_in  = NODE_W'(slot_ff);
            state_in = S_PATH_RD;
         end
         S_PATH_RD: begin
            if (node_ff == '0) begin
               fin   = 1'b1;
               fin_w = old_ff;
            end else begin
               s_re     = 1'b1;
               s_ra     = node_ff[IDX_W-1:0];
               state_in = S_PATH_WR;
            end
         end
         S_PATH_WR: begin
            s_we = 1'b1;
            s_wa = node_ff[IDX_W-1:0];
            s_wd = sum_new;
            if (node_ff == NODE_W'(1)) begin
               total_in = sum_new;
            end
            node_in  = node_ff >> 1;
            state_in = S_PATH_RD;
         end
         // find the lowest infinite slot
         S_SCAN_RD: begin
            w_re     = 1'b1;
            w_ra     = scan_ff[IDX_W-1:0];
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (w_rd_ff[WB_EFF]) begin
               slot_in  = scan_ff[IDX_W-1:0];
               old_in   = w_rd_ff;
               state_in = S_IDRD;
            end else begin
               scan_in  = scan_ff + NODE_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         // scale the fraction by the total in two partial products
         S_MUL1: begin
            prod_in  = PROD_W'(mul_res);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod_in  = prod_ff + (PROD_W'(mul_res) << LO_W);
            state_in = S_RSET;
         end
         S_RSET: begin
            r_in     = SUM_W'(prod_ff >> RANDOM_BITS);
            node_in  = NODE_W'(1);
            state_in = S_DRD;
         end
         // descend: own weight, then left subtree, then right
         S_DRD: begin
            if (node_ff > NODE_W'(SLOTS)) begin
               fin        = 1'b1;
               fin_status = wrst_pkg::STATUS_EMPTY;
               fin_id     = '0;
            end else begin
               w_re   = 1'b1;
               w_ra   = node_ff[IDX_W-1:0];
               wok_in = (node_ff <= NODE_W'(used_ff));
               lok_in = (child <= NODE_W'(used_ff));
               if (child <= NODE_W'(used_ff)) begin
                  s_re = 1'b1;
                  s_ra = child[IDX_W-1:0];
               end
               state_in = S_DW;
            end
         end
         S_DW: begin
            if (r_ff < wv) begin
               slot_in  = node_ff[IDX_W-1:0];
               old_in   = {1'b0, wv[WB_EFF-1:0]};
               state_in = S_IDRD;
            end else begin
               r_in     = r_ff - wv;
               state_in = S_DL;
            end
         end
         S_DL: begin
            if (r_ff < left) begin
               node_in = child;
            end else begin
               r_in    = r_ff - left;
               node_in = child | NODE_W'(1);
            end
            state_in = S_DRD;
         end
         S_IDRD: begin
            id_re    = 1'b1;
            id_ra    = slot_ff;
            state_in = S_IDGOT;
         end
         S_IDGOT: begin
            fin    = 1'b1;
            fin_id = id_rd_ff;
            fin_w  = old_ff;
         end
         default: state_in = S_IDLE;
      endcase

      // load the response register
      if (fin) begin
         rv_in                 = 1'b1;
         res_in.status         = fin_status;
         res_in.out_id         = fin_id;
         res_in.out_weight     = 32'(fin_w[WB_EFF-1:0]);
         res_in.out_infinite   = fin_w[WB_EFF];
         res_in.total_weight   = wrst_pkg::TOTAL_W'(total_ff);
         res_in.total_infinite = (infcnt_ff != '0);
         state_in              = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         used_ff   <= '0;
         infcnt_ff <= '0;
         total_ff  <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         infcnt_ff <= infcnt_in;
         total_ff  <= total_in;
         rv_ff     <= rv_in;
      end
   end

   // hold working payload
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      slot_ff  <= slot_in;
      scan_ff  <= scan_in;
      node_ff  <= node_in;
      r_ff     <= r_in;
      delta_ff <= delta_in;
      prod_ff  <= prod_in;
      old_ff   <= old_in;
      wok_ff   <= wok_in;
      lok_ff   <= lok_in;
      res_ff   <= res_in;
   end

   // weight memory
   always_ff @(posedge clock) begin
      if (w_we) begin
         mem_w[w_wa] <= w_wd;
      end
      if (w_re) begin
         w_rd_ff <= mem_w[w_ra];
      end
   end

   // subtree sum memory
   always_ff @(posedge clock) begin
      if (s_we) begin
         mem_s[s_wa] <= s_wd;
      end
      if (s_re) begin
         s_rd_ff <= mem_s[s_ra];
      end
   end

   // external id memory
   always_ff @(posedge clock) begin
      if (id_we) begin
         mem_id[id_wa] <= id_wd;
      end
      if (id_re) begin
         id_rd_ff <= mem_id[id_ra];
      end
   end

endmodule

### design/weighted_random_select_tree.sv
// ----------------------------------------------------------------------------
// weighted_random_select_tree: weighted random sampling over a sum tree
// Slots hold weights in heap order with subtree sums kept up to date.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_ch (set weight, draw, query), one response
// leaves on rsp_ch for every request. A two-entry queue takes requests while
// the engine works or a response waits, until the queue is full.
// Steps, from the engine picking up a request: a set or query walks the
// claimed slots for its id, claiming a new slot if none matches; a set then
// writes the weight and updates the sums on the path to the root. A draw
// scales its fraction by the total and descends the tree, or scans the slots
// for the lowest infinite entry when one exists, then reads the slot's id.
// One request is executed at a time.
// Reset empties the table at once: slots are claimed in order, and only
// claimed slots are ever used, so no clearing pass is needed.
// A stalled response holds in its register; the engine takes no new request
// until it has been transferred, and the queue fills behind it.
// ----------------------------------------------------------------------------
module weighted_random_select_tree #(
   parameter int SLOTS       = 256,
   parameter int WEIGHT_BITS = 32,
   parameter int RANDOM_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   wrst_req_if.sink   req_ch,
   wrst_rsp_if.source rsp_ch
);

   logic              cmd_valid;
   logic              pop;
   wrst_pkg::cmd_type cmd;

   wrst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .pop       (pop)
   );

   wrst_back #(
      .SLOTS       (SLOTS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .RANDOM_BITS (RANDOM_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .pop       (pop),
      .rsp       (rsp_ch)
   );

   // engine picks up work only with the response register free
   a_pop_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cmd_valid && !rsp_ch.valid))
      else $error("command taken while a response is pending");

   // one response per executed command
   a_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready) |=> !rsp_ch.valid)
      else $error("response repeated after transfer");

   // an infinite entry in a response means the table holds one
   a_inf_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.out_infinite) |-> rsp_ch.payload.total_infinite)
      else $error("infinite entry reported without infinite total");

   // an empty draw carries no id and no infinite entry
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.payload.status == wrst_pkg::STATUS_EMPTY))
         |-> (!rsp_ch.payload.total_infinite && (rsp_ch.payload.out_id == '0)))
      else $error("empty draw with entries present");

endmodule
